// File: hdl/ktp_pkg.sv
// Shared types, constants and note tables for the keypad tone player.
package ktp_pkg;

   localparam int NUM_KEYS   = 16;
   localparam int KEY_BITS   = 16;
   localparam int INDEX_W    = 4;
   localparam int NOTE_W     = 5;
   localparam int TOGGLE_W   = 11;
   localparam int PERIOD_W   = 7;

   localparam logic [NOTE_W-1:0] IDLE_NOTE = NOTE_W'(16);

   typedef struct packed {
      logic [KEY_BITS-1:0] key_pressed;
      logic                tick;
   } req_type;

   typedef struct packed {
      logic              speaker;
      logic              busy_res;
      logic [NOTE_W-1:0] note;
   } rsp_type;

   typedef struct packed {
      logic                speaker;
      logic                playing;
      logic [INDEX_W-1:0]  note_index;
      logic [TOGGLE_W-1:0] toggles_left;
      logic [PERIOD_W-1:0] period_count;
   } state_type;

   // Half period of each note, in ticks.
   function automatic logic [PERIOD_W-1:0] half_period(input logic [INDEX_W-1:0] idx);
      logic [PERIOD_W-1:0] val;
      case (idx)
         4'd0:    val = 7'd95;
         4'd1:    val = 7'd85;
         4'd2:    val = 7'd75;
         4'd3:    val = 7'd71;
         4'd4:    val = 7'd63;
         4'd5:    val = 7'd56;
         4'd6:    val = 7'd50;
         4'd7:    val = 7'd47;
         4'd8:    val = 7'd42;
         4'd9:    val = 7'd37;
         4'd10:   val = 7'd35;
         4'd11:   val = 7'd31;
         4'd12:   val = 7'd28;
         4'd13:   val = 7'd25;
         4'd14:   val = 7'd23;
         default: val = 7'd21;
      endcase
      return val;
   endfunction

   // Toggles that follow the first one of each note (table count less one).
   function automatic logic [TOGGLE_W-1:0] toggles_after_start(
      input logic [INDEX_W-1:0] idx);
      logic [TOGGLE_W-1:0] val;
      case (idx)
         4'd0:    val = 11'd260;
         4'd1:    val = 11'd292;
         4'd2:    val = 11'd328;
         4'd3:    val = 11'd348;
         4'd4:    val = 11'd391;
         4'd5:    val = 11'd439;
         4'd6:    val = 11'd493;
         4'd7:    val = 11'd522;
         4'd8:    val = 11'd586;
         4'd9:    val = 11'd658;
         4'd10:   val = 11'd697;
         4'd11:   val = 11'd784;
         4'd12:   val = 11'd879;
         4'd13:   val = 11'd987;
         4'd14:   val = 11'd1045;
         default: val = 11'd1173;
      endcase
      return val;
   endfunction

endpackage

// File: hdl/keypad_tone_player_top.sv
// Top level of the keypad tone player: handshake, note state and result register.
//
// Each item is one time step: the 16 key states and a tick flag. The block takes
// one item per clock cycle unless a result waits untaken, and returns exactly one
// result per item, in the cycle after the item is taken, from a result register; a
// new item is taken while the previous result is being taken or once it is gone. A
// single register stage lies between the note state update and the result port. While
// idle, the lowest-numbered pressed key starts a note and flips the speaker at once;
// while playing, keys are ignored and each tick counts down the half period.
// The result shows the speaker level, busy, and the playing key (16 when idle).
module keypad_tone_player_top (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  ktp_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output ktp_pkg::rsp_type rsp_data
);
   import ktp_pkg::*;

   state_type state_ff;
   state_type state_in;
   logic      rsp_valid_ff;
   logic      rsp_valid_in;
   rsp_type   rsp_data_ff;
   rsp_type   rsp_data_in;
   logic      req_take;

   // Take an item when the result register is empty or drains this cycle
   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign req_take  = req_valid && req_ready;

   ktp_step u_step (
      .cur_state (state_ff),
      .req_item  (req_data),
      .nxt_state (state_in)
   );

   // Build the result from the updated state
   always_comb begin
      rsp_data_in.speaker  = state_in.speaker;
      rsp_data_in.busy_res = state_in.playing;
      rsp_data_in.note     = state_in.playing ? {1'b0, state_in.note_index} : IDLE_NOTE;
      rsp_valid_in         = req_take ? 1'b1 : (rsp_valid_ff && !rsp_ready);
   end

   // Advance note state on each taken item
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= '0;
      end else if (req_take) begin
         state_ff <= state_in;
      end
   end

   // Hold the result until taken
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // A running note always has time left in its half period
   a_period_live: assert property (@(posedge clock) disable iff (reset)
      state_ff.playing |-> state_ff.period_count != '0)
      else $error("playing with an empty half period");

   // An idle item with a valid key starts a note and flips the speaker
   a_note_start: assert property (@(posedge clock) disable iff (reset)
      req_take && !state_ff.playing && (req_data.key_pressed[NUM_KEYS-1:0] != '0)
      |=> state_ff.playing && (state_ff.speaker != $past(state_ff.speaker)))
      else $error("note did not start on a pressed key");

   // A loaded result matches the state it came from
   a_rsp_matches: assert property (@(posedge clock) disable iff (reset)
      req_take |=> rsp_valid && rsp_data.speaker == state_ff.speaker &&
                   rsp_data.busy_res == state_ff.playing)
      else $error("result differs from note state");

   // Busy and the idle note code agree
   a_idle_note: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.busy_res == (rsp_data.note != IDLE_NOTE)))
      else $error("busy and note code disagree");

endmodule

// File: hdl/ktp_step.sv
// Next-state logic of the tone player for one item: key pick, half-period count, toggling.
module ktp_step (
   input  ktp_pkg::state_type cur_state,
   input  ktp_pkg::req_type   req_item,
   output ktp_pkg::state_type nxt_state
);
   import ktp_pkg::*;

   logic [INDEX_W-1:0]  key_idx;
   logic                key_found;
   logic [PERIOD_W-1:0] period_dec;

   // Pick the lowest-numbered pressed key below NUM_KEYS
   always_comb begin
      key_idx   = '0;
      key_found = 1'b0;
      for (int i = NUM_KEYS - 1; i >= 0; i--) begin
         if (req_item.key_pressed[i]) begin
            key_idx   = INDEX_W'(i);
            key_found = 1'b1;
         end
      end
   end

   // Count down the half period, saturating at zero
   assign period_dec = (cur_state.period_count != '0) ?
                       cur_state.period_count - PERIOD_W'(1) : '0;

   // Start a note when idle, otherwise advance the running note on a tick
   always_comb begin
      nxt_state = cur_state;
      if (!cur_state.playing) begin
         if (key_found) begin
            nxt_state.note_index   = key_idx;
            nxt_state.playing      = 1'b1;
            nxt_state.speaker      = ~cur_state.speaker;
            nxt_state.toggles_left = toggles_after_start(key_idx);
            nxt_state.period_count = half_period(key_idx);
         end
      end else if (req_item.tick) begin
         nxt_state.period_count = period_dec;
         if (period_dec == '0) begin
            if (cur_state.toggles_left != '0) begin
               nxt_state.speaker      = ~cur_state.speaker;
               nxt_state.toggles_left = cur_state.toggles_left - TOGGLE_W'(1);
               nxt_state.period_count = half_period(cur_state.note_index);
            end else begin
               nxt_state.playing = 1'b0;
            end
         end
      end
   end

endmodule
